FILE: hw/rtl/fsns_pkg.sv
// ----------------------------------------------------------------------------
// fsns_pkg
// Shared types and constants for the FAT 8.3 short name search block.
// ----------------------------------------------------------------------------
package fsns_pkg;

    localparam int NAME_LEN    = 11;
    localparam int HEAD_BYTES  = 8;
    localparam int TAIL_BYTES  = 3;
    localparam int POS_W       = 4;
    localparam int COUNT_W     = 12;
    localparam int STATUS_W    = 2;

    localparam logic [POS_W-1:0]   EXT_POS        = 4'd8;
    localparam logic [POS_W-1:0]   NAME_END_POS   = 4'd11;
    localparam logic [7:0]         SKIP_TYPE_BITS = 8'h18;
    localparam logic [7:0]         SPACE_CHAR     = 8'h20;
    localparam logic [7:0]         DOT_CHAR       = 8'h2E;
    localparam logic [7:0]         NUL_CHAR       = 8'h00;
    localparam logic [7:0]         LOWER_A        = 8'h61;
    localparam logic [7:0]         LOWER_Z        = 8'h7A;
    localparam logic [7:0]         CASE_OFFSET    = 8'h20;
    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RESET = 12'd224;

    localparam logic ACT_NAME_CHAR = 1'b0;
    localparam logic ACT_ENTRY     = 1'b1;

    localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef logic [NAME_LEN-1:0][7:0] fsns_name_t;

    typedef struct packed {
        logic                      action;
        logic                      first_char;
        logic [7:0]                name_char;
        logic [HEAD_BYTES*8-1:0]   entry_name_head;
        logic [TAIL_BYTES*8-1:0]   entry_name_tail;
        logic [7:0]                entry_type;
    } fsns_item_t;

    typedef struct packed {
        logic       take_char;
        logic       clear;
        logic [7:0] ch;
        logic       close;
    } fsns_name_cmd_t;

endpackage

FILE: hw/rtl/fsns_if.sv
// ----------------------------------------------------------------------------
// fsns_if
// Valid/ready channels of the short name search: input items, results and
// the configuration write channel.
// ----------------------------------------------------------------------------
interface fsns_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic        first_char;
    logic [7:0]  name_char;
    logic [63:0] entry_name_head;
    logic [23:0] entry_name_tail;
    logic [7:0]  entry_type;

    modport source (
        output valid, action, first_char, name_char, entry_name_head,
               entry_name_tail, entry_type,
        input  ready
    );
    modport sink (
        input  valid, action, first_char, name_char, entry_name_head,
               entry_name_tail, entry_type,
        output ready
    );
    modport mon (
        input valid, ready, action, first_char, name_char, entry_name_head,
              entry_name_tail, entry_type
    );
endinterface

interface fsns_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] entry_index;

    modport source (output valid, status, entry_index, input ready);
    modport sink (input valid, status, entry_index, output ready);
    modport mon (input valid, ready, status, entry_index);
endinterface

interface fsns_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
    modport mon (input valid, ready, data);
endinterface

FILE: hw/rtl/fsns_name_packer.sv
// ----------------------------------------------------------------------------
// fsns_name_packer
// Packs search name characters into the space-filled 11-byte 8.3 form.
// ----------------------------------------------------------------------------
module fsns_name_packer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fsns_pkg::fsns_name_cmd_t cmd,
    output fsns_pkg::fsns_name_t    packed_name
);
    import fsns_pkg::*;

    fsns_name_t       name_reg, name_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             closed_reg, closed_next;
    logic [7:0]       ch_upper;

    always_comb
    begin
        name_next   = name_reg;
        pos_next    = pos_reg;
        closed_next = closed_reg;
        ch_upper    = cmd.ch;
        if (cmd.ch >= LOWER_A && cmd.ch <= LOWER_Z)
        begin
            ch_upper = cmd.ch - CASE_OFFSET;
        end
        if (cmd.take_char)
        begin
            if (cmd.clear)
            begin
                name_next   = {NAME_LEN{SPACE_CHAR}};
                pos_next    = '0;
                closed_next = 1'b0;
            end
            if (!closed_next && pos_next < NAME_END_POS)
            begin
                if (cmd.ch == NUL_CHAR)
                begin
                    closed_next = 1'b1;
                end
                else if (cmd.ch == DOT_CHAR && pos_next <= EXT_POS)
                begin
                    pos_next = EXT_POS;
                end
                else
                begin
                    name_next[pos_next] = ch_upper;
                    pos_next            = pos_next + 1'b1;
                end
            end
        end
        else if (cmd.close)
        begin
            closed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_reg   <= {NAME_LEN{SPACE_CHAR}};
            pos_reg    <= '0;
            closed_reg <= 1'b0;
        end
        else
        begin
            name_reg   <= name_next;
            pos_reg    <= pos_next;
            closed_reg <= closed_next;
        end
    end

    assign packed_name = name_reg;

endmodule

FILE: hw/rtl/fsns_entry_search.sv
// ----------------------------------------------------------------------------
// fsns_entry_search
// Checks one directory entry against the packed name, keeps the entry
// counter and holds the result register.
// ----------------------------------------------------------------------------
module fsns_entry_search (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  fsns_pkg::fsns_item_t          item,
    input  fsns_pkg::fsns_name_t          packed_name,
    input  logic [fsns_pkg::COUNT_W-1:0]  max_entries,
    input  logic                          out_ready,
    output logic                          finished,
    output logic                          out_valid,
    output logic [fsns_pkg::STATUS_W-1:0] out_status,
    output logic [fsns_pkg::COUNT_W-1:0]  out_index
);
    import fsns_pkg::*;

    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                done_reg, done_next;
    logic                valid_reg, valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [COUNT_W-1:0]  index_reg;
    logic                produce;
    logic                name_match;
    fsns_name_t          entry_name;

    always_comb
    begin
        for (int i = 0; i < HEAD_BYTES; i++)
        begin
            entry_name[i] = item.entry_name_head[(HEAD_BYTES-1-i)*8 +: 8];
        end
        for (int i = 0; i < TAIL_BYTES; i++)
        begin
            entry_name[HEAD_BYTES+i] = item.entry_name_tail[(TAIL_BYTES-1-i)*8 +: 8];
        end
    end

    assign name_match = (entry_name == packed_name);
    assign produce    = advance && item.action == ACT_ENTRY && !done_reg;

    always_comb
    begin
        count_next  = count_reg;
        done_next   = done_reg;
        status_next = status_reg;
        valid_next  = valid_reg && !out_ready;
        if (advance && item.action == ACT_NAME_CHAR && item.first_char)
        begin
            count_next = '0;
            done_next  = 1'b0;
        end
        if (produce)
        begin
            valid_next = 1'b1;
            if (count_reg >= max_entries || entry_name[0] == NUL_CHAR)
            begin
                status_next = ST_NOT_FOUND;
                done_next   = 1'b1;
            end
            else if ((item.entry_type & SKIP_TYPE_BITS) != 8'h00)
            begin
                status_next = ST_NO_MATCH;
                count_next  = count_reg + 1'b1;
            end
            else if (name_match)
            begin
                status_next = ST_FOUND;
                done_next   = 1'b1;
            end
            else
            begin
                status_next = ST_NO_MATCH;
                count_next  = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        if (produce)
        begin
            index_reg <= count_reg;
        end
    end

    assign finished   = done_reg;
    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_index  = index_reg;

endmodule

FILE: hw/rtl/fat_short_name_search_top.sv
// ----------------------------------------------------------------------------
// fat_short_name_search_top
// FAT 8.3 short name search over a stream of name characters and entries.
//
// in_ch carries one item per beat: a search name character (action 0) or a
// directory entry (action 1). A name character with first_char set starts a
// new search. Each entry beat yields one result beat on out_ch (no match,
// found, not found) with its position in the search; name characters and
// entries after the search has ended yield none. cfg writes max_entries,
// the entry limit; it is accepted on any cycle, so write it only while the
// block is idle.
//
// An item is held in the input register and its result enters the result
// register when the item advances. Throughput: one item per cycle unless
// out_ch stalls, set by the single pass of the byte pack and 88-bit
// compare between those two registers.
//
// Reset clears the name to spaces, the counters and both registers; the
// limit returns to 224. When out_ch stalls, the input register holds and
// in_ch ready drops once it is full.
// ----------------------------------------------------------------------------
module fat_short_name_search_top (
    input  logic       clk,
    input  logic       rst_n,
    fsns_in_if.sink    in_ch,
    fsns_out_if.source out_ch,
    fsns_cfg_if.sink   cfg
);
    import fsns_pkg::*;

    fsns_item_t         item_reg;
    logic               item_valid_reg;
    logic [COUNT_W-1:0] max_entries_reg;
    logic               advance;
    logic               finished;
    logic               out_valid;
    fsns_name_t         packed_name;
    fsns_name_cmd_t     name_cmd;

    assign advance     = item_valid_reg && (!out_valid || out_ch.ready);
    assign in_ch.ready = !item_valid_reg || advance;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else
        begin
            if (in_ch.ready)
            begin
                item_valid_reg <= in_ch.valid;
            end
            if (cfg.valid)
            begin
                max_entries_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            item_reg.action          <= in_ch.action;
            item_reg.first_char      <= in_ch.first_char;
            item_reg.name_char       <= in_ch.name_char;
            item_reg.entry_name_head <= in_ch.entry_name_head;
            item_reg.entry_name_tail <= in_ch.entry_name_tail;
            item_reg.entry_type      <= in_ch.entry_type;
        end
    end

    always_comb
    begin
        name_cmd.take_char = advance && item_reg.action == ACT_NAME_CHAR;
        name_cmd.clear     = item_reg.first_char;
        name_cmd.ch        = item_reg.name_char;
        name_cmd.close     = advance && item_reg.action == ACT_ENTRY && !finished;
    end

    fsns_name_packer u_packer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (name_cmd),
        .packed_name (packed_name)
    );

    fsns_entry_search u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (item_reg),
        .packed_name (packed_name),
        .max_entries (max_entries_reg),
        .out_ready   (out_ch.ready),
        .finished    (finished),
        .out_valid   (out_valid),
        .out_status  (out_ch.status),
        .out_index   (out_ch.entry_index)
    );

    assign out_ch.valid = out_valid;

endmodule

FILE: hw/rtl/fsns_checker.sv
// ----------------------------------------------------------------------------
// fsns_checker
// Port-level checks of the short name search, bound to the top level.
// ----------------------------------------------------------------------------
module fsns_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [fsns_pkg::STATUS_W-1:0] out_status,
    input logic [fsns_pkg::COUNT_W-1:0]  out_entry_index
);
    import fsns_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(out_status) && $stable(out_entry_index))
        else $error("stalled result beat changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == ST_NO_MATCH ||
                       out_status == ST_FOUND ||
                       out_status == ST_NOT_FOUND))
        else $error("invalid status code");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

bind fat_short_name_search_top fsns_checker u_fsns_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_entry_index (out_ch.entry_index)
);
